// ----- hdl/dvrt_pkg.sv -----
`timescale 1ns / 1ps
package dvrt_pkg;
   localparam int TABLE_SLOTS = 32;
   localparam int SLOT_W = $clog2(TABLE_SLOTS);
   localparam int PORT_COUNT = 4;
   localparam logic [15:0] TIMEOUT_RESET = 16'd20;

   localparam logic [1:0] MODE_LOOKUP = 2'd0;
   localparam logic [1:0] MODE_LEARN = 2'd1;
   localparam logic [1:0] MODE_CONNECT = 2'd2;
   localparam logic [1:0] MODE_TICK = 2'd3;

   typedef struct packed {
      logic [1:0] mode;
      logic [31:0] address;
      logic [31:0] prefix_mask;
      logic [31:0] gateway_addr;
      logic [3:0] hop_metric;
      logic [1:0] arrival_port;
   } req_type;

   typedef struct packed {
      logic hit;
      logic [31:0] route_gateway;
      logic [1:0] route_port;
      logic [4:0] route_metric;
      logic table_changed;
      logic table_full;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic [SLOT_W-1:0] idx;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic done;
   } sts_type;
endpackage

// ----- hdl/dvrt_req_if.sv -----
`timescale 1ns / 1ps
interface dvrt_req_if;
   logic valid;
   logic ready;
   dvrt_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/dvrt_rsp_if.sv -----
`timescale 1ns / 1ps
interface dvrt_rsp_if;
   logic valid;
   logic ready;
   dvrt_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/distance_vector_route_table_top.sv -----
`timescale 1ns / 1ps
// An accepted word is handled in order: the scan of every table slot, the update
//   step and the result output (states SCAN, DONE and OUT).
// No new word is accepted until the result of the last one has been taken.
// Slot data is fetched one slot ahead of the scan, one slot per cycle.
// Reset (synchronous, high): table empty, time 0, timeout 20.
module distance_vector_route_table_top (
   input logic clock,
   input logic reset,
   dvrt_req_if.sink req_ch,
   dvrt_rsp_if.source rsp_ch,
   input logic csr_write_enable,
   input logic [15:0] csr_write_data
);
   dvrt_pkg::cmd_type cmd;
   dvrt_pkg::sts_type sts;

   dvrt_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
      .cmd(cmd), .sts(sts)
   );

   dvrt_datapath u_dp (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req(req_ch.payload), .cmd(cmd), .sts(sts), .rsp(rsp_ch.payload)
   );
endmodule

// ----- hdl/dvrt_ctrl.sv -----
`timescale 1ns / 1ps
module dvrt_ctrl (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input logic rsp_ready,
   output dvrt_pkg::cmd_type cmd,
   input dvrt_pkg::sts_type sts
);
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_DONE = 4'b0100,
      ST_OUT = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [dvrt_pkg::SLOT_W-1:0] idx_ff, idx_in;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd = '0;
      cmd.idx = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               idx_in = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == dvrt_pkg::SLOT_W'(dvrt_pkg::TABLE_SLOTS - 1)) state_in = ST_DONE;
         end
         ST_DONE: begin
            cmd.finish = 1'b1;
            if (sts.done) state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
      end
   end
endmodule

// ----- hdl/dvrt_datapath.sv -----
`timescale 1ns / 1ps
module dvrt_datapath (
   input logic clock,
   input logic reset,
   input logic csr_write_enable,
   input logic [15:0] csr_write_data,
   input dvrt_pkg::req_type req,
   input dvrt_pkg::cmd_type cmd,
   output dvrt_pkg::sts_type sts,
   output dvrt_pkg::rsp_type rsp
);
   localparam int N = dvrt_pkg::TABLE_SLOTS;
   localparam int SW = dvrt_pkg::SLOT_W;

   logic [N-1:0] valid_ff;
   logic [31:0] pfx_mem [N];
   logic [31:0] msk_mem [N];
   logic [31:0] gw_mem [N];
   logic [1:0] port_mem [N];
   logic [4:0] met_mem [N];
   logic [15:0] stamp_mem [N];

   logic [15:0] timeout_ff, time_ff;
   dvrt_pkg::req_type req_ff;
   logic found_ff, free_found_ff, best_any_ff;
   logic [SW-1:0] found_ff_idx, free_ff;
   logic [31:0] best_mask_ff;
   logic [31:0] best_gw_ff;
   logic [1:0] best_port_ff;
   logic [4:0] best_met_ff;
   logic changed_ff;
   dvrt_pkg::rsp_type rsp_ff, rsp_in;

   // slot data, fetched one slot ahead of the scan index
   logic [SW-1:0] rd_addr;
   logic [31:0] rd_pfx_ff, rd_msk_ff, rd_gw_ff;
   logic [1:0] rd_port_ff;
   logic [4:0] rd_met_ff;
   logic [15:0] rd_stamp_ff;
   logic s_valid, match, port_ok, expired, adds_route;
   logic [4:0] nm;
   logic [31:0] net;

   assign rd_addr = cmd.load ? '0 : cmd.idx + 1'b1;
   assign s_valid = valid_ff[cmd.idx];
   assign net = req_ff.address & req_ff.prefix_mask;
   assign nm = {1'b0, req_ff.hop_metric} + 5'd1;
   assign port_ok = 32'(req_ff.arrival_port) < dvrt_pkg::PORT_COUNT;
   assign expired = s_valid && ((time_ff - rd_stamp_ff) >= timeout_ff);
   assign adds_route = port_ok && !found_ff && free_found_ff &&
                       (req_ff.mode inside {dvrt_pkg::MODE_LEARN, dvrt_pkg::MODE_CONNECT});

   always_comb begin
      case (req_ff.mode)
         dvrt_pkg::MODE_LOOKUP:
            match = s_valid && ((rd_pfx_ff & rd_msk_ff) == (req_ff.address & rd_msk_ff));
         dvrt_pkg::MODE_LEARN: match = s_valid && ((rd_pfx_ff & rd_msk_ff) == net);
         dvrt_pkg::MODE_CONNECT: match = s_valid && (rd_pfx_ff == net);
         default: match = 1'b0;
      endcase
   end

   always_comb begin
      rsp_in = '0;
      case (req_ff.mode)
         dvrt_pkg::MODE_LOOKUP: if (best_any_ff) begin
            rsp_in.hit = 1'b1;
            rsp_in.route_gateway = best_gw_ff;
            rsp_in.route_port = best_port_ff;
            rsp_in.route_metric = best_met_ff;
         end
         dvrt_pkg::MODE_LEARN: if (port_ok) begin
            if (!found_ff) begin
               rsp_in.table_changed = free_found_ff;
               rsp_in.table_full = !free_found_ff;
            end else rsp_in.table_changed = (best_met_ff > nm);
         end
         dvrt_pkg::MODE_CONNECT: if (port_ok && !found_ff) begin
            rsp_in.table_changed = free_found_ff;
            rsp_in.table_full = !free_found_ff;
         end
         default: rsp_in.table_changed = changed_ff;
      endcase
   end

   assign sts.done = cmd.finish;
   assign rsp = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         timeout_ff <= dvrt_pkg::TIMEOUT_RESET;
         time_ff <= '0;
      end else begin
         if (csr_write_enable) timeout_ff <= csr_write_data;
         if (cmd.load && req.mode == dvrt_pkg::MODE_TICK) time_ff <= time_ff + 16'd1;
         if (cmd.scan && req_ff.mode == dvrt_pkg::MODE_TICK && expired)
            valid_ff[cmd.idx] <= 1'b0;
         if (cmd.finish && adds_route) valid_ff[free_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load || cmd.scan) begin
         rd_pfx_ff <= pfx_mem[rd_addr];
         rd_msk_ff <= msk_mem[rd_addr];
         rd_gw_ff <= gw_mem[rd_addr];
         rd_port_ff <= port_mem[rd_addr];
         rd_met_ff <= met_mem[rd_addr];
         rd_stamp_ff <= stamp_mem[rd_addr];
      end
      if (cmd.load) begin
         req_ff <= req;
         found_ff <= 1'b0;
         free_found_ff <= 1'b0;
         best_any_ff <= 1'b0;
         best_mask_ff <= '0;
         changed_ff <= 1'b0;
      end
      if (cmd.scan) begin
         if (match && !found_ff) begin
            found_ff <= 1'b1;
            found_ff_idx <= cmd.idx;
         end
         if (!s_valid && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_ff <= cmd.idx;
         end
         if (req_ff.mode == dvrt_pkg::MODE_LOOKUP && match && rd_msk_ff >= best_mask_ff) begin
            best_any_ff <= 1'b1;
            best_mask_ff <= rd_msk_ff;
            best_gw_ff <= rd_gw_ff;
            best_port_ff <= rd_port_ff;
            best_met_ff <= rd_met_ff;
         end
         if (req_ff.mode == dvrt_pkg::MODE_TICK && expired) changed_ff <= 1'b1;
         // match slot captured for the write-back step
         if (req_ff.mode != dvrt_pkg::MODE_LOOKUP && match && !found_ff) begin
            best_port_ff <= rd_port_ff;
            best_met_ff <= rd_met_ff;
         end
      end
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
         case (req_ff.mode)
            dvrt_pkg::MODE_LEARN: if (port_ok) begin
               if (!found_ff) begin
                  if (free_found_ff) begin
                     pfx_mem[free_ff] <= req_ff.address;
                     msk_mem[free_ff] <= req_ff.prefix_mask;
                     gw_mem[free_ff] <= req_ff.gateway_addr;
                     port_mem[free_ff] <= req_ff.arrival_port;
                     met_mem[free_ff] <= nm;
                     stamp_mem[free_ff] <= time_ff;
                  end
               end else if (best_met_ff > nm) begin
                  gw_mem[found_ff_idx] <= req_ff.gateway_addr;
                  port_mem[found_ff_idx] <= req_ff.arrival_port;
                  met_mem[found_ff_idx] <= nm;
                  stamp_mem[found_ff_idx] <= time_ff;
               end else if (best_port_ff == req_ff.arrival_port && best_met_ff == nm)
                  stamp_mem[found_ff_idx] <= time_ff;
            end
            dvrt_pkg::MODE_CONNECT: if (port_ok) begin
               if (!found_ff) begin
                  if (free_found_ff) begin
                     pfx_mem[free_ff] <= net;
                     msk_mem[free_ff] <= req_ff.prefix_mask;
                     gw_mem[free_ff] <= '0;
                     port_mem[free_ff] <= req_ff.arrival_port;
                     met_mem[free_ff] <= '0;
                     stamp_mem[free_ff] <= time_ff;
                  end
               end else begin
                  gw_mem[found_ff_idx] <= '0;
                  port_mem[found_ff_idx] <= req_ff.arrival_port;
                  met_mem[found_ff_idx] <= '0;
                  stamp_mem[found_ff_idx] <= time_ff;
               end
            end
            default: ;
         endcase
      end
   end
endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
   localparam int SLOTS = dvrt_pkg::TABLE_SLOTS;
   localparam logic [1:0] M_LOOKUP = dvrt_pkg::MODE_LOOKUP;
   localparam logic [1:0] M_LEARN = dvrt_pkg::MODE_LEARN;
   localparam logic [1:0] M_CONNECT = dvrt_pkg::MODE_CONNECT;
   localparam logic [1:0] M_TICK = dvrt_pkg::MODE_TICK;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [15:0] csr_write_data = 16'd0;

   dvrt_req_if req_ch();
   dvrt_rsp_if rsp_ch();

   distance_vector_route_table_top u_dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   always #1 clock = ~clock;

   // shadow routing table
   logic        tbl_valid [SLOTS];
   logic [31:0] tbl_prefix [SLOTS];
   logic [31:0] tbl_mask [SLOTS];
   logic [31:0] tbl_gateway [SLOTS];
   logic [1:0]  tbl_port [SLOTS];
   logic [4:0]  tbl_metric [SLOTS];
   logic [15:0] tbl_stamp [SLOTS];
   logic [15:0] now_ticks;
   logic [15:0] age_limit;

   dvrt_pkg::rsp_type pending_routes[$];
   int errors = 0;
   int cycles = 0;
   int unsigned n_sent = 0;

   function automatic int lowest_free();
      for (int i = 0; i < SLOTS; i++)
         if (!tbl_valid[i]) return i;
      return -1;
   endfunction

   function automatic void add_route(input logic [31:0] pfx, input logic [31:0] msk,
                                     input logic [31:0] gw, input logic [1:0] port,
                                     input logic [4:0] met, output logic ok);
      int s;
      s = lowest_free();
      ok = (s >= 0);
      if (ok) begin
         tbl_valid[s] = 1'b1;
         tbl_prefix[s] = pfx;
         tbl_mask[s] = msk;
         tbl_gateway[s] = gw;
         tbl_port[s] = port;
         tbl_metric[s] = met;
         tbl_stamp[s] = now_ticks;
      end
   endfunction

   function automatic dvrt_pkg::rsp_type route_table_step(input dvrt_pkg::req_type w);
      dvrt_pkg::rsp_type r;
      int m;
      logic [31:0] most;
      logic [31:0] net;
      logic [4:0] nm;
      logic ok;
      r = '0;
      m = -1;
      most = 0;
      case (w.mode)
         M_LOOKUP: begin
            for (int i = 0; i < SLOTS; i++)
               if (tbl_valid[i] && (tbl_prefix[i] & tbl_mask[i]) == (w.address & tbl_mask[i])
                   && tbl_mask[i] >= most) begin
                  most = tbl_mask[i];
                  m = i;
               end
            if (m >= 0) begin
               r.hit = 1'b1;
               r.route_gateway = tbl_gateway[m];
               r.route_port = tbl_port[m];
               r.route_metric = tbl_metric[m];
            end
         end
         M_LEARN: if (w.arrival_port < dvrt_pkg::PORT_COUNT) begin
            nm = {1'b0, w.hop_metric} + 5'd1;
            net = w.address & w.prefix_mask;
            for (int i = 0; i < SLOTS && m < 0; i++)
               if (tbl_valid[i] && (tbl_prefix[i] & tbl_mask[i]) == net) m = i;
            if (m < 0) begin
               add_route(w.address, w.prefix_mask, w.gateway_addr, w.arrival_port, nm, ok);
               r.table_changed = ok;
               r.table_full = !ok;
            end else if (tbl_metric[m] > nm) begin
               tbl_port[m] = w.arrival_port;
               tbl_gateway[m] = w.gateway_addr;
               tbl_metric[m] = nm;
               tbl_stamp[m] = now_ticks;
               r.table_changed = 1'b1;
            end else if (tbl_port[m] == w.arrival_port && tbl_metric[m] == nm) begin
               tbl_stamp[m] = now_ticks;
            end
         end
         M_CONNECT: if (w.arrival_port < dvrt_pkg::PORT_COUNT) begin
            net = w.address & w.prefix_mask;
            for (int i = 0; i < SLOTS && m < 0; i++)
               if (tbl_valid[i] && tbl_prefix[i] == net) m = i;
            if (m < 0) begin
               add_route(net, w.prefix_mask, 32'd0, w.arrival_port, 5'd0, ok);
               r.table_changed = ok;
               r.table_full = !ok;
            end else begin
               tbl_metric[m] = 5'd0;
               tbl_port[m] = w.arrival_port;
               tbl_gateway[m] = 32'd0;
               tbl_stamp[m] = now_ticks;
            end
         end
         default: begin
            now_ticks = now_ticks + 16'd1;
            for (int i = 0; i < SLOTS; i++)
               if (tbl_valid[i] && 16'(now_ticks - tbl_stamp[i]) >= age_limit) begin
                  tbl_valid[i] = 1'b0;
                  r.table_changed = 1'b1;
               end
         end
      endcase
      return r;
   endfunction

   // directed rows: typed expectation used only where has_exp is set
   typedef struct {
      dvrt_pkg::req_type w;
      logic has_exp;
      dvrt_pkg::rsp_type exp;
   } row_type;

   function automatic dvrt_pkg::req_type mk(input logic [1:0] md, input logic [31:0] a,
                                            input logic [31:0] msk, input logic [31:0] nh,
                                            input logic [3:0] hm, input logic [1:0] p);
      dvrt_pkg::req_type w;
      w.mode = md;
      w.address = a;
      w.prefix_mask = msk;
      w.gateway_addr = nh;
      w.hop_metric = hm;
      w.arrival_port = p;
      return w;
   endfunction

   function automatic dvrt_pkg::rsp_type rs(input logic h, input logic [31:0] gw,
                                            input logic [1:0] p, input logic [4:0] met,
                                            input logic ch, input logic fl);
      dvrt_pkg::rsp_type r;
      r.hit = h;
      r.route_gateway = gw;
      r.route_port = p;
      r.route_metric = met;
      r.table_changed = ch;
      r.table_full = fl;
      return r;
   endfunction

   row_type directed[$];

   initial begin
      directed.push_back('{mk(M_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0, 0), 1, rs(0, 0, 0, 0, 0, 0)});
      directed.push_back('{mk(M_TICK, 0, 0, 0, 0, 0), 1, rs(0, 0, 0, 0, 0, 0)});
      directed.push_back('{mk(M_CONNECT, 32'h0A01_0203, 32'hFFFF_FF00, 0, 0, 3), 1,
                           rs(0, 0, 0, 0, 1, 0)});
      directed.push_back('{mk(M_LOOKUP, 32'h0A01_02FF, 0, 0, 0, 0), 1, rs(1, 0, 3, 0, 0, 0)});
      directed.push_back('{mk(M_LEARN, 32'hC0A8_0000, 32'hFFFF_0000, 32'hFFFF_FFFF, 15, 0),
                           1, rs(0, 0, 0, 0, 1, 0)});
      directed.push_back('{mk(M_LOOKUP, 32'hC0A8_1234, 0, 0, 0, 0), 1,
                           rs(1, 32'hFFFF_FFFF, 0, 16, 0, 0)});
      directed.push_back('{mk(M_LEARN, 32'hC0A8_0000, 32'hFFFF_0000, 32'h1, 0, 2), 0, '0});
      directed.push_back('{mk(M_LEARN, 32'hC0A8_0000, 32'hFFFF_0000, 32'h2, 0, 2), 0, '0});
      directed.push_back('{mk(M_LEARN, 32'hC0A8_0000, 32'hFFFF_0000, 32'h3, 5, 1), 0, '0});
      directed.push_back('{mk(M_LOOKUP, 32'hC0A8_0001, 0, 0, 0, 0), 0, '0});
      directed.push_back('{mk(M_CONNECT, 32'hC0A8_0077, 32'hFFFF_0000, 0, 0, 1), 0, '0});
      directed.push_back('{mk(M_LEARN, 0, 0, 32'h0B0B_0B0B, 3, 1), 0, '0});
      directed.push_back('{mk(M_LOOKUP, 32'h1234_5678, 0, 0, 0, 0), 0, '0});
      directed.push_back('{mk(M_LEARN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h5, 14, 2), 0, '0});
      directed.push_back('{mk(M_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0, 0), 0, '0});
      directed.push_back('{mk(M_TICK, 0, 0, 0, 0, 0), 0, '0});
   end

   // valid stays up after a handshake unless an idle gap follows
   task automatic send_word(input dvrt_pkg::req_type w);
      int gap;
      gap = $urandom_range(0, 12);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= w;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      n_sent++;
   endtask

   task automatic send_predicted(input dvrt_pkg::req_type w);
      pending_routes.push_back(route_table_step(w));
      send_word(w);
   endtask

   task automatic drain_and_set(input logic [15:0] v);
      req_ch.valid <= 1'b0;
      while (pending_routes.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      age_limit = v;
   endtask

   function automatic logic [31:0] rand_mask();
      int len;
      len = $urandom_range(0, 32);
      if ($urandom_range(0, 9) == 0) return $urandom();
      return (len == 0) ? 32'd0 : ~(32'hFFFF_FFFF >> len);
   endfunction

   // small address pool so routes collide, refresh and match
   function automatic dvrt_pkg::req_type rand_word();
      dvrt_pkg::req_type w;
      int k;
      k = $urandom_range(0, 99);
      w.mode = (k < 30) ? M_LOOKUP : (k < 65) ? M_LEARN : (k < 80) ? M_CONNECT : M_TICK;
      w.address = ($urandom_range(0, 4) == 0) ? $urandom()
                : {8'd10, 6'd0, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                   8'($urandom_range(0, 255))};
      w.prefix_mask = rand_mask();
      w.gateway_addr = $urandom();
      w.hop_metric = 4'($urandom_range(0, 15));
      w.arrival_port = 2'($urandom_range(0, 3));
      return w;
   endfunction

   initial begin
      dvrt_pkg::rsp_type exp;
      req_ch.valid <= 1'b0;
      req_ch.payload <= '0;
      for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
      now_ticks = 16'd0;
      age_limit = dvrt_pkg::TIMEOUT_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) begin
         exp = route_table_step(directed[i].w);
         pending_routes.push_back(directed[i].has_exp ? directed[i].exp : exp);
         send_word(directed[i].w);
      end
      // fill the table to overflow
      for (int i = 0; i < SLOTS + 3; i++)
         send_predicted(mk(M_CONNECT, {8'd20, 8'(i), 16'd0}, 32'hFFFF_0000, 0, 0, 2'(i)));
      send_predicted(mk(M_LEARN, 32'h3300_0000, 32'hFF00_0000, 1, 1, 1));
      drain_and_set(16'd1);
      send_predicted(mk(M_TICK, 0, 0, 0, 0, 0));
      send_predicted(mk(M_LOOKUP, 32'h1400_0000, 0, 0, 0, 0));
      drain_and_set(16'd65535);
      for (int i = 0; i < 300; i++) send_predicted(rand_word());
      drain_and_set(16'd3);
      for (int i = 0; i < 500; i++) send_predicted(rand_word());
      drain_and_set(16'd0);
      send_predicted(mk(M_TICK, 0, 0, 0, 0, 0));
      drain_and_set(16'd12);
      for (int i = 0; i < 450; i++) send_predicted(rand_word());
      req_ch.valid <= 1'b0;
      while (pending_routes.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // ready stays up after a handshake unless a stall follows
   initial begin
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      forever begin
         int stall;
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_routes.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result word %h", rsp_ch.payload);
         end else begin
            dvrt_pkg::rsp_type e;
            e = pending_routes.pop_front();
            if (e.hit !== rsp_ch.payload.hit
                || e.route_gateway !== rsp_ch.payload.route_gateway
                || e.route_port !== rsp_ch.payload.route_port
                || e.route_metric !== rsp_ch.payload.route_metric
                || e.table_changed !== rsp_ch.payload.table_changed
                || e.table_full !== rsp_ch.payload.table_full) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: expected hit=%b gw=%h port=%0d met=%0d chg=%b full=%b,",
                           e.hit, e.route_gateway, e.route_port, e.route_metric,
                           e.table_changed, e.table_full,
                           " got hit=%b gw=%h port=%0d met=%0d chg=%b full=%b",
                           rsp_ch.payload.hit, rsp_ch.payload.route_gateway,
                           rsp_ch.payload.route_port, rsp_ch.payload.route_metric,
                           rsp_ch.payload.table_changed, rsp_ch.payload.table_full);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == 400000) begin
         $display("FAILURE");
         $finish;
      end
   end
endmodule

// ----- files.f -----
hdl/dvrt_pkg.sv
hdl/dvrt_req_if.sv
hdl/dvrt_rsp_if.sv
hdl/dvrt_ctrl.sv
hdl/dvrt_datapath.sv
hdl/distance_vector_route_table_top.sv
tb/testbench.sv
